@@ rtl/core/hkt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkt_pkg
// Types, constants and translation tables for the HID key to terminal byte
// translator.
// ----------------------------------------------------------------------------
package hkt_pkg;

    localparam int unsigned COUNTER_BITS_DEF = 16;
    localparam int unsigned QUEUE_DEPTH_DEF  = 4;

    localparam logic [15:0] FIRST_DELAY_RST = 16'd500;
    localparam logic [15:0] NEXT_DELAY_RST  = 16'd33;

    typedef enum logic [0:0] {
        CFG_FIRST_DELAY = 1'b0,
        CFG_NEXT_DELAY  = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        FUNC_REPORT = 1'b0,
        FUNC_TICK   = 1'b1
    } t_func;

    localparam logic [7:0] KEY_EMPTY  = 8'h00;
    localparam logic [7:0] KEY_A      = 8'h04;
    localparam logic [7:0] KEY_Z      = 8'h1D;
    localparam logic [7:0] KEY_1      = 8'h1E;
    localparam logic [7:0] KEY_0      = 8'h27;
    localparam logic [7:0] KEY_ENTER  = 8'h28;
    localparam logic [7:0] KEY_ESC    = 8'h29;
    localparam logic [7:0] KEY_BKSP   = 8'h2A;
    localparam logic [7:0] KEY_TAB    = 8'h2B;
    localparam logic [7:0] KEY_SPACE  = 8'h2C;
    localparam logic [7:0] KEY_MINUS  = 8'h2D;
    localparam logic [7:0] KEY_NONUS  = 8'h32;
    localparam logic [7:0] KEY_SLASH  = 8'h38;
    localparam logic [7:0] KEY_CAPS   = 8'h39;
    localparam logic [7:0] KEY_F1     = 8'h3A;
    localparam logic [7:0] KEY_F12    = 8'h45;
    localparam logic [7:0] KEY_SCROLL = 8'h47;
    localparam logic [7:0] KEY_RIGHT  = 8'h4F;
    localparam logic [7:0] KEY_UP     = 8'h52;
    localparam logic [7:0] KEY_NUMLK  = 8'h53;

    localparam logic [7:0] CHR_ESC  = 8'h1B;
    localparam logic [7:0] CHR_CR   = 8'h0D;
    localparam logic [7:0] CHR_BS   = 8'h08;
    localparam logic [7:0] CHR_TAB  = 8'h09;
    localparam logic [7:0] CHR_SP   = 8'h20;
    localparam logic [7:0] CHR_LBR  = 8'h5B;
    localparam logic [7:0] CHR_TIL  = 8'h7E;
    localparam logic [7:0] CHR_LC_A = 8'h61;
    localparam logic [7:0] CHR_UC_A = 8'h41;

    localparam logic [7:0] DIGIT_LO [10] = '{
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30};
    localparam logic [7:0] DIGIT_HI [10] = '{
        8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29};
    localparam logic [7:0] PUNCT_LO [12] = '{
        8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h5C, 8'h00,
        8'h3B, 8'h27, 8'h60, 8'h2C, 8'h2E, 8'h2F};
    localparam logic [7:0] PUNCT_HI [12] = '{
        8'h5F, 8'h2B, 8'h7B, 8'h7D, 8'h7C, 8'h00,
        8'h3A, 8'h22, 8'h7E, 8'h3C, 8'h3E, 8'h3F};
    // F1..F12 sequence digits: 11..15, 17..21, 23, 24
    localparam logic [7:0] FKEY_TENS [12] = '{
        8'h31, 8'h31, 8'h31, 8'h31, 8'h31, 8'h31,
        8'h31, 8'h31, 8'h32, 8'h32, 8'h32, 8'h32};
    localparam logic [7:0] FKEY_ONES [12] = '{
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h37,
        8'h38, 8'h39, 8'h30, 8'h31, 8'h33, 8'h34};
    // right, left, down, up
    localparam logic [7:0] ARROW_CHR [4] = '{8'h43, 8'h44, 8'h42, 8'h41};

    typedef struct packed {
        logic       func;
        logic [7:0] usage;
        logic       shift;
        logic       ctrl;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic       caps_led;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] code;
        logic       shift;
        logic       caps;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_xfer;

    function automatic logic key_exempt(input logic [7:0] code);
        return (code == KEY_EMPTY) || (code == KEY_ENTER) || (code == KEY_ESC) ||
               (code == KEY_TAB) || (code == KEY_CAPS) || (code == KEY_SCROLL) ||
               (code == KEY_NUMLK);
    endfunction

    // number of bytes a key emits
    function automatic logic [2:0] key_len(input logic [7:0] code);
        logic [2:0] n;
        n = 3'd0;
        if (code >= KEY_A && code <= KEY_CAPS && code != KEY_NONUS) begin
            n = 3'd1;
        end else if (code >= KEY_F1 && code <= KEY_F12) begin
            n = 3'd5;
        end else if (code >= KEY_RIGHT && code <= KEY_UP) begin
            n = 3'd3;
        end
        return n;
    endfunction

    function automatic logic [7:0] key_byte(input logic [7:0] code, input logic shift,
                                            input logic caps, input logic [2:0] idx);
        logic [7:0] b;
        logic [7:0] off;
        b = 8'h00;
        off = 8'h00;
        if (code >= KEY_A && code <= KEY_Z) begin
            off = code - KEY_A;
            b = ((caps ^ shift) ? CHR_UC_A : CHR_LC_A) + off;
        end else if (code >= KEY_1 && code <= KEY_0) begin
            off = code - KEY_1;
            b = shift ? DIGIT_HI[off[3:0]] : DIGIT_LO[off[3:0]];
        end else if (code == KEY_ENTER) begin
            b = CHR_CR;
        end else if (code == KEY_ESC) begin
            b = CHR_ESC;
        end else if (code == KEY_BKSP) begin
            b = CHR_BS;
        end else if (code == KEY_TAB) begin
            b = CHR_TAB;
        end else if (code == KEY_SPACE) begin
            b = CHR_SP;
        end else if (code >= KEY_MINUS && code <= KEY_SLASH) begin
            off = code - KEY_MINUS;
            b = shift ? PUNCT_HI[off[3:0]] : PUNCT_LO[off[3:0]];
        end else if (code >= KEY_F1 && code <= KEY_F12) begin
            off = code - KEY_F1;
            case (idx)
                3'd0:    b = CHR_ESC;
                3'd1:    b = CHR_LBR;
                3'd2:    b = FKEY_TENS[off[3:0]];
                3'd3:    b = FKEY_ONES[off[3:0]];
                default: b = CHR_TIL;
            endcase
        end else if (code >= KEY_RIGHT && code <= KEY_UP) begin
            off = code - KEY_RIGHT;
            case (idx)
                3'd0:    b = CHR_ESC;
                3'd1:    b = CHR_LBR;
                default: b = ARROW_CHR[off[1:0]];
            endcase
        end
        return b;
    endfunction

endpackage

@@ rtl/core/hkt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkt_front
// Takes reports and ticks, keeps key, modifier, caps and repeat state, and
// posts one translation job per transaction that produces output.
// ----------------------------------------------------------------------------
module hkt_front
    import hkt_pkg::*;
#(
    parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in_item    i_data,
    input  logic        i_full,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    output t_job_xfer   o_push
);

    logic [15:0]             r_first, r_next;
    logic [7:0]              r_held, n_held;
    logic [COUNTER_BITS-1:0] r_cnt, n_cnt, dec_cnt;
    logic                    r_caps, n_caps;
    logic                    r_shift, n_shift;
    logic                    r_ctrl, n_ctrl;
    logic                    accept;

    assign accept  = i_valid && !i_full;
    assign dec_cnt = r_cnt - 1'b1;

    always_comb begin
        n_held = r_held;
        n_cnt = r_cnt;
        n_caps = r_caps;
        n_shift = r_shift;
        n_ctrl = r_ctrl;
        o_push.valid = 1'b0;
        o_push.job.code = r_held;
        o_push.job.shift = r_shift;
        o_push.job.caps = r_caps;
        if (accept) begin
            if (i_data.func == FUNC_REPORT) begin
                n_shift = i_data.shift;
                n_ctrl = i_data.ctrl;
                if (i_data.usage != r_held) begin
                    n_held = i_data.usage;
                    if (!key_exempt(i_data.usage) && !i_data.ctrl) begin
                        n_cnt = COUNTER_BITS'(r_first);
                    end else begin
                        n_cnt = '0;
                    end
                    if (i_data.usage == KEY_CAPS) begin
                        n_caps = ~r_caps;
                    end
                    o_push.valid = (key_len(i_data.usage) != 3'd0);
                    o_push.job.code = i_data.usage;
                    o_push.job.shift = i_data.shift;
                    o_push.job.caps = n_caps;
                end
            end else if (r_cnt != '0) begin
                if (dec_cnt != '0) begin
                    n_cnt = dec_cnt;
                end else begin
                    n_cnt = COUNTER_BITS'(r_next);
                    if (r_held == KEY_CAPS) begin
                        n_caps = ~r_caps;
                    end
                    o_push.valid = (key_len(r_held) != 3'd0);
                    o_push.job.caps = n_caps;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= FIRST_DELAY_RST;
            r_next <= NEXT_DELAY_RST;
            r_held <= KEY_EMPTY;
            r_cnt <= '0;
            r_caps <= 1'b0;
            r_shift <= 1'b0;
            r_ctrl <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_addr == CFG_FIRST_DELAY) begin
                r_first <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_addr == CFG_NEXT_DELAY) begin
                r_next <= i_cfg_wdata;
            end
            r_held <= n_held;
            r_cnt <= n_cnt;
            r_caps <= n_caps;
            r_shift <= n_shift;
            r_ctrl <= n_ctrl;
        end
    end

endmodule

@@ rtl/core/hkt_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkt_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module hkt_queue
    import hkt_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job_xfer i_push,
    input  logic      i_pop,
    output logic      o_full,
    output t_job_xfer o_head
);

    localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

    t_job            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_count;

    assign o_full = (r_count == CntFull);
    assign o_head.valid = (r_count != '0);
    assign o_head.job = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= (r_wr == PtrLast) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrLast) ? '0 : r_rd + 1'b1;
            end
            if (i_push.valid && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push.valid) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.valid)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_head.valid |-> !i_pop)
        else $error("job popped from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntFull)
        else $error("queue count beyond depth");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.valid && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow push");

endmodule

@@ rtl/core/hkt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkt_back
// Expands the job at the queue head into output bytes, one per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module hkt_back
    import hkt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job_xfer i_head,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    logic       r_valid;
    t_out_item  r_data;
    logic [2:0] r_idx;
    logic [2:0] len;
    logic       advance;
    logic       is_last;

    assign len     = key_len(i_head.job.code);
    assign is_last = (r_idx == len - 3'd1);
    assign advance = i_head.valid && (!r_valid || !i_stall);
    assign o_pop   = advance && is_last;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_data.kind <= (i_head.job.code == KEY_CAPS);
            r_data.out_byte <= key_byte(i_head.job.code, i_head.job.shift,
                                        i_head.job.caps, r_idx);
            r_data.caps_led <= i_head.job.caps;
            r_data.last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx <= 3'd0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_idx <= is_last ? 3'd0 : r_idx + 3'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head.valid |-> (r_idx < len))
        else $error("byte index beyond job length");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head.valid |-> (r_idx == 3'd0))
        else $error("byte index left over without a job");

    a_last_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_valid && r_data.last))
        else $error("job popped without a final byte");

endmodule

@@ rtl/core/hid_key_to_terminal_bytes_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_key_to_terminal_bytes_top
// HID key usage codes to terminal bytes, with typematic repeat.
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_stall   i_in_data  (t_in_item)
//   output   out        o_out_valid / i_out_stall o_out_data (t_out_item)
//   config   in         i_cfg_we                  i_cfg_addr, i_cfg_wdata
//
// One transaction is taken per cycle while the job queue has room.
// Output runs at one byte per cycle while i_out_stall is low; a key gives
// 0, 1, 3 or 5 bytes.
// The first byte of a taken transaction is registered in the queue, then in the output register.
// Synchronous active-low reset; no clearing pass.
// o_in_stall follows queue fullness only; o_out_valid is registered, with no combinational path from stall.
// ----------------------------------------------------------------------------
module hid_key_to_terminal_bytes_top
    import hkt_pkg::*;
#(
    parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF,
    parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    t_job_xfer push;
    t_job_xfer head;
    logic      full;
    logic      pop;

    assign o_in_stall = full;

    hkt_front #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_data      (i_in_data),
        .i_full      (full),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push)
    );

    hkt_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    hkt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hid_key_to_terminal_bytes_top. Key reports and timer
// ticks are driven from a queue under random gaps and back-pressure. Each
// accepted transaction is run through a behavioural model of the translator
// and typematic timer, and every output transaction is checked against the
// oldest predicted byte. Covers directed keys, caps lock, escape sequences,
// exempt keys, ctrl suppression and repeat, then random typing sessions over
// several delay settings, zero and full-scale delays included.
// ----------------------------------------------------------------------------
module tb;
    import hkt_pkg::*;

    localparam int RST_CYCLES    = 6;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 1000;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_EVENTS  = 44;

    localparam logic [191:0] DIGIT_PLAIN = "1234567890";
    localparam logic [191:0] DIGIT_SH    = "!@#$%^&*()";
    localparam logic [191:0] PUNCT_PLAIN = "-=[]\\ ;'`,./";
    localparam logic [191:0] PUNCT_SH    = "_+{}| :\"~<>?";
    localparam logic [191:0] FKEY_NUMS   = "111213141517181920212324";
    localparam logic [191:0] ARROW_CHRS  = "CDBA";

    typedef struct packed {
        logic     drain_first;
        t_in_item ev;
    } t_key_event;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_data   = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [0:0]  i_cfg_addr  = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;

    // translator state
    logic [7:0]  held_code   = '0;
    logic [15:0] repeat_left = '0;
    logic        caps_on     = 1'b0;
    logic        shift_on    = 1'b0;
    logic        ctrl_on     = 1'b0;
    logic [15:0] first_delay = FIRST_DELAY_RST;
    logic [15:0] next_delay  = NEXT_DELAY_RST;

    t_key_event  key_events [$];
    t_out_item   bytes_due [$];

    int   n_queued    = 0;
    int   n_taken     = 0;
    int   n_errors    = 0;
    int   idle_cycles = 0;
    int   in_gap      = 0;
    int   out_wait    = 0;
    logic in_fire     = 1'b0;
    logic out_fire    = 1'b0;
    logic no_gaps     = 1'b0;
    logic [7:0] typed_code = '0;

    hid_key_to_terminal_bytes_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [7:0] char_at(input logic [191:0] s, input int len, input int i);
        return s[8*(len-1-i) +: 8];
    endfunction

    function automatic void push_byte(input logic kind, input logic [7:0] b);
        t_out_item r;
        r.kind     = kind;
        r.out_byte = b;
        r.caps_led = caps_on;
        r.last     = 1'b0;
        bytes_due.push_back(r);
    endfunction

    function automatic void key_to_bytes(input logic [7:0] code);
        int        n0;
        int        k;
        t_out_item r;
        n0 = bytes_due.size();
        if (code >= KEY_A && code <= KEY_Z) begin
            push_byte(1'b0, ((caps_on ^ shift_on) ? 8'h41 : 8'h61) + (code - KEY_A));
        end else if (code >= KEY_1 && code <= KEY_0) begin
            push_byte(1'b0, char_at(shift_on ? DIGIT_SH : DIGIT_PLAIN, 10, code - KEY_1));
        end else if (code == KEY_ENTER) begin
            push_byte(1'b0, 8'h0D);
        end else if (code == KEY_ESC) begin
            push_byte(1'b0, 8'h1B);
        end else if (code == KEY_BKSP) begin
            push_byte(1'b0, 8'h08);
        end else if (code == KEY_TAB) begin
            push_byte(1'b0, 8'h09);
        end else if (code == KEY_SPACE) begin
            push_byte(1'b0, 8'h20);
        end else if (code >= KEY_MINUS && code <= KEY_SLASH) begin
            if (code != KEY_NONUS) begin
                push_byte(1'b0, char_at(shift_on ? PUNCT_SH : PUNCT_PLAIN, 12, code - KEY_MINUS));
            end
        end else if (code == KEY_CAPS) begin
            caps_on = ~caps_on;
            push_byte(1'b1, 8'h00);
        end else if (code >= KEY_F1 && code <= KEY_F12) begin
            k = code - KEY_F1;
            push_byte(1'b0, 8'h1B);
            push_byte(1'b0, "[");
            push_byte(1'b0, char_at(FKEY_NUMS, 24, 2 * k));
            push_byte(1'b0, char_at(FKEY_NUMS, 24, 2 * k + 1));
            push_byte(1'b0, "~");
        end else if (code >= KEY_RIGHT && code <= KEY_UP) begin
            push_byte(1'b0, 8'h1B);
            push_byte(1'b0, "[");
            push_byte(1'b0, char_at(ARROW_CHRS, 4, code - KEY_RIGHT));
        end
        if (bytes_due.size() > n0) begin
            r = bytes_due.pop_back();
            r.last = 1'b1;
            bytes_due.push_back(r);
        end
    endfunction

    function automatic logic no_repeat_key(input logic [7:0] code);
        return code == KEY_EMPTY || code == KEY_ENTER || code == KEY_ESC || code == KEY_TAB ||
               code == KEY_CAPS || code == KEY_SCROLL || code == KEY_NUMLK;
    endfunction

    function automatic void translate_item(input t_in_item ev);
        if (ev.func == FUNC_REPORT) begin
            shift_on = ev.shift;
            ctrl_on  = ev.ctrl;
            if (ev.usage != held_code) begin
                held_code   = ev.usage;
                repeat_left = (no_repeat_key(held_code) || ctrl_on) ? 16'd0 : first_delay;
                key_to_bytes(held_code);
            end
        end else if (repeat_left != 16'd0) begin
            repeat_left = repeat_left - 16'd1;
            if (repeat_left == 16'd0) begin
                repeat_left = next_delay;
                key_to_bytes(held_code);
            end
        end
    endfunction

    function automatic void add_event(input t_func f, input logic [7:0] code, input logic sh,
                                      input logic ct, input logic drain);
        t_key_event s;
        s.drain_first  = drain;
        s.ev.func      = f;
        s.ev.usage     = code;
        s.ev.shift     = sh;
        s.ev.ctrl      = ct;
        key_events.push_back(s);
        n_queued++;
    endfunction

    function automatic void add_tick();
        add_event(FUNC_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
    endfunction

    function automatic void add_random_event();
        logic [7:0] code;
        logic       drain;
        drain = ($urandom_range(0, 39) == 0);
        if ($urandom_range(0, 1) == 0) begin
            add_event(FUNC_TICK, 8'($urandom), 1'($urandom), 1'($urandom), drain);
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: code = 8'($urandom_range(KEY_A, KEY_UP));
                6: begin
                    case ($urandom_range(0, 6))
                        0:       code = KEY_EMPTY;
                        1:       code = KEY_ENTER;
                        2:       code = KEY_ESC;
                        3:       code = KEY_TAB;
                        4:       code = KEY_CAPS;
                        5:       code = KEY_SCROLL;
                        default: code = KEY_NUMLK;
                    endcase
                end
                7:       code = typed_code;
                8:       code = 8'($urandom);
                default: code = KEY_EMPTY;
            endcase
            typed_code = code;
            add_event(FUNC_REPORT, code, 1'($urandom), $urandom_range(0, 4) == 0, drain);
        end
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == CFG_FIRST_DELAY) begin
            first_delay = val;
        end else begin
            next_delay = val;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (n_taken != n_queued || bytes_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_bytes
        t_out_item want;
        in_fire  = i_rst_n && i_in_valid && !o_in_stall;
        out_fire = i_rst_n && o_out_valid && !i_out_stall;
        if (in_fire) begin
            translate_item(i_in_data);
            n_taken++;
        end
        if (out_fire) begin
            if (bytes_due.size() == 0) begin
                $error("unexpected transaction: kind %0d out_byte %02h", o_out_data.kind,
                       o_out_data.out_byte);
                n_errors++;
            end else begin
                want = bytes_due.pop_front();
                if (o_out_data.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_out_data.kind);
                    n_errors++;
                end
                if (o_out_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte,
                           o_out_data.out_byte);
                    n_errors++;
                end
                if (o_out_data.caps_led !== want.caps_led) begin
                    $error("caps_led: expected %0d, got %0d", want.caps_led,
                           o_out_data.caps_led);
                    n_errors++;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_out_data.last);
                    n_errors++;
                end
            end
        end
        idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(negedge i_clk) begin : drive_keys
        logic     nv;
        t_in_item nd;
        nv = i_in_valid;
        nd = i_in_data;
        if (in_fire) begin
            nv     = 1'b0;
            in_gap = no_gaps ? 0 : $urandom_range(0, 3);
        end
        if (!nv) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (key_events.size() > 0 &&
                         !(key_events[0].drain_first && bytes_due.size() != 0)) begin
                nd = key_events[0].ev;
                nv = 1'b1;
                void'(key_events.pop_front());
            end
        end
        i_in_valid <= nv;
        i_in_data  <= nd;
    end

    always @(negedge i_clk) begin : drive_stall
        if (out_fire) begin
            out_wait = no_gaps ? 0 : $urandom_range(0, 3);
        end else if (out_wait == 0 && !no_gaps && $urandom_range(0, 7) == 0) begin
            out_wait = 1;
        end
        if (out_wait > 0) begin
            i_out_stall <= 1'b1;
            out_wait--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin : run_test
        logic [15:0] d_first;
        logic [15:0] d_next;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset delays: plain translation, repeat never reached
        add_event(FUNC_REPORT, KEY_A, 1'b0, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_Z, 1'b1, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_CAPS, 1'b0, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_A, 1'b0, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_Z, 1'b1, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_CAPS, 1'b0, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_1, 1'b1, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_0, 1'b0, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_ENTER, 1'b0, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_ESC, 1'b0, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_BKSP, 1'b0, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_TAB, 1'b0, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_SPACE, 1'b0, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_MINUS, 1'b1, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_NONUS, 1'b0, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_SLASH, 1'b1, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_F12, 1'b1, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_UP, 1'b0, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_UP, 1'b1, 1'b1, 1'b0);
        add_event(FUNC_REPORT, 8'hFF, 1'b0, 1'b0, 1'b0);
        add_event(FUNC_REPORT, 8'h64, 1'b0, 1'b0, 1'b0);
        add_event(FUNC_REPORT, KEY_EMPTY, 1'b0, 1'b0, 1'b0);
        wait_idle();

        // short delays: repeat, modifier update on held key, silent and exempt keys
        write_reg(CFG_FIRST_DELAY, 16'd2);
        write_reg(CFG_NEXT_DELAY, 16'd1);
        @(posedge i_clk);
        add_event(FUNC_REPORT, KEY_A, 1'b0, 1'b0, 1'b0);
        add_tick();
        add_tick();
        add_tick();
        add_event(FUNC_REPORT, KEY_A, 1'b1, 1'b0, 1'b0);
        add_tick();
        add_event(FUNC_REPORT, 8'h46, 1'b0, 1'b0, 1'b0);
        add_tick();
        add_tick();
        add_event(FUNC_REPORT, KEY_CAPS, 1'b0, 1'b0, 1'b0);
        add_tick();
        add_event(FUNC_REPORT, KEY_F1, 1'b0, 1'b1, 1'b1);
        add_tick();
        add_tick();
        wait_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       begin d_first = 16'd1;     d_next = 16'd1;     end
                1:       begin d_first = 16'hFFFF;  d_next = 16'hFFFF;  end
                2:       begin d_first = 16'd0;     d_next = 16'd3;     end
                3:       begin d_first = 16'd2;     d_next = 16'd0;     end
                4:       begin d_first = 16'd1;     d_next = 16'hFFFF;  end
                default: begin
                    d_first = 16'($urandom_range(1, 6));
                    d_next  = 16'($urandom_range(1, 4));
                end
            endcase
            write_reg(CFG_FIRST_DELAY, d_first);
            write_reg(CFG_NEXT_DELAY, d_next);
            @(posedge i_clk);
            no_gaps = (ph == 2) || ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_EVENTS; i++) begin
                add_random_event();
            end
            wait_idle();
        end

        if (n_errors == 0 && bytes_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
